/* src/msfb_pkg.sv */
`default_nettype none
package msfb_pkg;

	localparam int unsigned FRAME_LEN = 17;
	localparam int unsigned HDR_LEN   = 7;
	localparam int unsigned CRC_SPAN  = 15;
	localparam int unsigned IDX_W     = 5;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// fixed header: slave addr, function, start reg, reg count, byte count
	localparam logic [7:0] HDR_SLAVE  = 8'h01;
	localparam logic [7:0] HDR_FUNC   = 8'h10;
	localparam logic [7:0] HDR_REG_HI = 8'h00;
	localparam logic [7:0] HDR_REG_LO = 8'h0A;
	localparam logic [7:0] HDR_CNT_HI = 8'h00;
	localparam logic [7:0] HDR_CNT_LO = 8'h04;
	localparam logic [7:0] HDR_BYTES  = 8'h08;

	// frame positions
	localparam logic [IDX_W-1:0] POS_VOLT   = 5'd7;
	localparam logic [IDX_W-1:0] POS_CURR   = 5'd11;
	localparam logic [IDX_W-1:0] POS_CRC_LO = 5'd15;
	localparam logic [IDX_W-1:0] POS_CRC_HI = 5'd16;

	typedef struct packed {
		logic [31:0] voltage_bits;
		logic [31:0] current_bits;
	} setpoint_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_t;

	typedef struct packed {
		logic       clear;
		logic       step;
		logic [7:0] data;
	} crc_ctl_t;

	function automatic logic [7:0] header_byte(input logic [2:0] pos);
		logic [7:0] b;
		case (pos)
			3'd0: b = HDR_SLAVE;
			3'd1: b = HDR_FUNC;
			3'd2: b = HDR_REG_HI;
			3'd3: b = HDR_REG_LO;
			3'd4: b = HDR_CNT_HI;
			3'd5: b = HDR_CNT_LO;
			3'd6: b = HDR_BYTES;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

/* src/msfb_crc.sv */
`default_nettype none
module msfb_crc (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire msfb_pkg::crc_ctl_t ctl,
	output logic [15:0]           crc
);

	logic [15:0] crc_q;
	logic [15:0] crc_d;

	// one frame byte folded per cycle while step is set, eight shift/xor steps
	always_comb begin
		crc_d = crc_q ^ {8'h00, ctl.data};
		for (int i = 0; i < 8; i++) begin
			if (crc_d[0]) begin
				crc_d = (crc_d >> 1) ^ msfb_pkg::CRC_POLY;
			end else begin
				crc_d = crc_d >> 1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= msfb_pkg::CRC_INIT;
		end else if (ctl.clear) begin
			crc_q <= msfb_pkg::CRC_INIT;
		end else if (ctl.step) begin
			crc_q <= crc_d;
		end
	end

	assign crc = crc_q;

endmodule
`default_nettype wire

/* src/msfb_seq.sv */
`default_nettype none
module msfb_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire msfb_pkg::setpoint_t setpoint,
	input  wire logic [15:0]         crc,
	output logic                     busy,
	output logic                     strobe,
	output msfb_pkg::frame_t         frame,
	output msfb_pkg::crc_ctl_t       crc_ctl
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SEND = 1'b1;

	logic                       state_q;
	logic [msfb_pkg::IDX_W-1:0] idx_q;
	logic [31:0]                volt_q;
	logic [31:0]                curr_q;
	logic                       accept;
	logic                       at_last;
	logic [msfb_pkg::IDX_W-1:0] off;
	logic [31:0]                word;
	logic [7:0]                 word_byte;
	logic [7:0]                 out_byte;

	assign at_last = (state_q == ST_SEND) && (idx_q == msfb_pkg::POS_CRC_HI);
	// free again during the final byte so frames run back to back
	assign busy    = (state_q == ST_SEND) && !at_last;
	assign accept  = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else if (accept) begin
			state_q <= ST_SEND;
			idx_q   <= '0;
		end else if (at_last) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else if (state_q == ST_SEND) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			volt_q <= setpoint.voltage_bits;
			curr_q <= setpoint.current_bits;
		end
	end

	// byte select
	always_comb begin
		off  = idx_q - msfb_pkg::POS_VOLT;
		word = (idx_q < msfb_pkg::POS_CURR) ? volt_q : curr_q;
		case (off[1:0])
			2'd0: word_byte = word[15:8];
			2'd1: word_byte = word[7:0];
			2'd2: word_byte = word[31:24];
			2'd3: word_byte = word[23:16];
			default: word_byte = 8'h00;
		endcase
		if (idx_q < msfb_pkg::POS_VOLT) begin
			out_byte = msfb_pkg::header_byte(idx_q[2:0]);
		end else if (idx_q < msfb_pkg::POS_CRC_LO) begin
			out_byte = word_byte;
		end else if (idx_q == msfb_pkg::POS_CRC_LO) begin
			out_byte = crc[7:0];
		end else begin
			out_byte = crc[15:8];
		end
	end

	assign strobe           = (state_q == ST_SEND);
	assign frame.frame_byte = out_byte;
	assign frame.last_byte  = at_last;

	assign crc_ctl.clear = accept;
	assign crc_ctl.step  = (state_q == ST_SEND) && (idx_q < msfb_pkg::POS_CRC_LO);
	assign crc_ctl.data  = out_byte;

	a_accept_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_SEND) && (idx_q == '0) && (crc == msfb_pkg::CRC_INIT))
		else $error("accepted request did not restart frame");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND) |-> (idx_q <= msfb_pkg::POS_CRC_HI))
		else $error("byte index out of frame");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !at_last) |=> strobe && (idx_q == $past(idx_q) + 1'b1))
		else $error("gap inside frame");

	a_end_or_next: assert property (@(posedge clk) disable iff (!arst_n)
		(at_last && !start) |=> !strobe)
		else $error("strobe after last byte without request");

	a_crc_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && idx_q >= msfb_pkg::POS_CRC_LO && !accept) |=> $stable(crc))
		else $error("crc moved while being sent");

endmodule
`default_nettype wire

/* src/modbus_setpoint_frame_builder.sv */
`default_nettype none
// Modbus RTU write-multiple-registers frame builder with CRC-16/Modbus.
// The first frame byte is on the result ports the cycle after the request is taken.
// Frame: 17 bytes, one per cycle, from the byte sequencer, which feeds the CRC unit
// one byte per cycle for bytes 0..14. A new request is taken in the cycle of the
// final byte. The receiver cannot stall; strobe marks each byte.
// Reset (arst_n low, asynchronous): idle, busy and strobe low, CRC at FFFF.
module modbus_setpoint_frame_builder (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire msfb_pkg::setpoint_t setpoint,
	output logic                     busy,
	output logic                     strobe,
	output msfb_pkg::frame_t         frame
);

	// sequencer <-> CRC unit
	msfb_pkg::crc_ctl_t crc_ctl;
	logic [15:0]        crc;

	// Sequencer: holds the two setpoint words, walks byte positions 0..16,
	// picks header / word / CRC bytes and tells the CRC unit what to fold.
	msfb_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.setpoint (setpoint),
		.crc      (crc),
		.busy     (busy),
		.strobe   (strobe),
		.frame    (frame),
		.crc_ctl  (crc_ctl)
	);

	// CRC unit: cleared on each new request, folds bytes 0..14 as they go out,
	// then holds its value while the low and high CRC bytes are sent.
	msfb_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	a_last_has_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		frame.last_byte |-> strobe)
		else $error("last flag without strobe");

	a_busy_means_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> strobe && !frame.last_byte)
		else $error("busy outside frame");

	a_start_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> strobe)
		else $error("request not started");

endmodule
`default_nettype wire
